// ===== rtl/core/hrd_pkg.sv =====
// hrd_pkg: shared constants, codes and character tables of the http request deframer
package hrd_pkg;

    localparam int BUFFER_BYTES   = 8192;
    localparam int PATH_MAX_BYTES = 63;

    localparam int CNT_W   = $clog2(BUFFER_BYTES);
    localparam int PATH_W  = $clog2(PATH_MAX_BYTES + 1);
    localparam int LEN_W   = 14;
    localparam int OUT_W   = 13;
    localparam int SUM_W   = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [2:0] GET_LEN  = 3'd4;
    localparam logic [2:0] POST_LEN = 3'd5;
    localparam logic [3:0] NAME_LEN = 4'd15;

    typedef enum logic [5:0] {
        PH_METHOD = 6'b000001,
        PH_PATH   = 6'b000010,
        PH_HEAD   = 6'b000100,
        PH_BAD    = 6'b001000,
        PH_BODY   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        NUM_IDLE   = 4'b0001,
        NUM_SPACE  = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_END    = 4'b1000
    } t_num_phase;

    function automatic logic [7:0] get_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "G";
            3'd1:    c = "E";
            3'd2:    c = "T";
            3'd3:    c = " ";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "P";
            3'd1:    c = "O";
            3'd2:    c = "S";
            3'd3:    c = "T";
            3'd4:    c = " ";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hrd_in_if.sv =====
// hrd_in_if: request byte channel of the http request deframer
interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

// ===== rtl/core/hrd_out_if.sv =====
// hrd_out_if: result channel of the http request deframer
interface hrd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        method;
    logic [12:0] body_length;
    logic [12:0] head_length;
    logic        last;

    modport source (output valid, output kind, output value, output method,
                    output body_length, output head_length, output last, input ready);
    modport sink   (input valid, input kind, input value, input method,
                    input body_length, input head_length, input last, output ready);
endinterface

// ===== rtl/core/http_request_deframer.sv =====
// http_request_deframer: byte-wise http request header parser with path and body passing
//
// channel  dir  handshake        payload
// i_req    in   valid / ready    start_req, data_byte
// o_res    out  valid / ready    kind, value, method, body_length, head_length, last
//
// one request byte per cycle while no result stalls; bytes and results are both registered
// the rate is set by the update of the parser state from the input register
// synchronous active-low reset clears all parser state at once, no clearing pass
// a stalled result holds in the result register; the input register keeps accepting
// until it is full behind a stalled result
module http_request_deframer import hrd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrd_in_if.sink     i_req,
    hrd_out_if.source  o_res
);

    logic       r_in_valid;
    logic       r_in_start;
    logic [7:0] r_in_byte;

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_bytes, n_bytes;
    logic [2:0]        r_mm, n_mm;
    logic              r_post, n_post;
    logic [PATH_W-1:0] r_pcount, n_pcount;
    logic [1:0]        r_end, n_end;
    logic [3:0]        r_name, n_name;
    t_num_phase        r_nph, n_nph;
    logic              r_neg, n_neg;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_bcount, n_bcount;
    logic [CNT_W-1:0]  r_btarget, n_btarget;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [7:0]        r_out_value;
    logic              r_out_method;
    logic [OUT_W-1:0]  r_out_body;
    logic [OUT_W-1:0]  r_out_head;
    logic              r_out_last;

    logic              process;
    logic              e_valid;
    logic [1:0]        e_kind;
    logic [7:0]        e_value;
    logic              e_last;
    logic              e_method;
    logic [OUT_W-1:0]  e_body;
    logic [OUT_W-1:0]  e_head;

    assign process     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || process;

    always_comb begin
        logic [7:0]         b;
        logic [7:0]         c;
        logic [2:0]         mlen;
        logic               space;
        logic               digit;
        logic               end_hit;
        logic               known;
        logic [LEN_W+3:0]   v;
        logic [LEN_W-1:0]   tgt_raw;

        b         = r_in_byte;
        c         = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        space     = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
        digit     = (b >= "0" && b <= "9");
        end_hit   = 1'b0;
        v         = '0;
        tgt_raw   = '0;

        n_phase   = r_phase;
        n_bytes   = r_bytes;
        n_mm      = r_mm;
        n_post    = r_post;
        n_pcount  = r_pcount;
        n_end     = r_end;
        n_name    = r_name;
        n_nph     = r_nph;
        n_neg     = r_neg;
        n_len     = r_len;
        n_head    = r_head;
        n_bcount  = r_bcount;
        n_btarget = r_btarget;
        e_valid   = 1'b0;
        e_kind    = KIND_PATH;
        e_value   = '0;
        e_last    = 1'b0;

        if (process) begin
            if (r_in_start) begin
                n_phase   = PH_METHOD;
                n_bytes   = '0;
                n_mm      = '0;
                n_post    = 1'b0;
                n_pcount  = '0;
                n_end     = '0;
                n_name    = '0;
                n_nph     = NUM_IDLE;
                n_neg     = 1'b0;
                n_len     = '0;
                n_head    = '0;
                n_bcount  = '0;
                n_btarget = '0;
            end
            if (n_phase != PH_DONE && n_bytes < CNT_W'(BUFFER_BYTES - 1)) begin
                n_bytes = n_bytes + 1'b1;
                if (n_phase == PH_BODY) begin
                    n_bcount = n_bcount + 1'b1;
                    e_valid  = 1'b1;
                    e_kind   = KIND_BODY;
                    e_value  = b;
                    e_last   = (n_bcount >= n_btarget);
                    if (e_last) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    // method and path
                    mlen = n_post ? POST_LEN : GET_LEN;
                    unique case (n_phase)
                        PH_METHOD: begin
                            if (n_mm == '0) begin
                                if (b == "G") begin
                                    n_post = 1'b0;
                                    n_mm   = 3'd1;
                                end else if (b == "P") begin
                                    n_post = 1'b1;
                                    n_mm   = 3'd1;
                                end else begin
                                    n_phase = PH_BAD;
                                end
                            end else if (n_mm < mlen &&
                                         b == (n_post ? post_char(n_mm) : get_char(n_mm))) begin
                                n_mm = n_mm + 1'b1;
                                if (n_mm == mlen) begin
                                    n_phase = PH_PATH;
                                end
                            end else begin
                                n_phase = PH_BAD;
                            end
                        end
                        PH_PATH: begin
                            if (b == CH_SP || b == "?" || b == CH_CR || b == CH_LF ||
                                b == CH_NUL) begin
                                n_phase = PH_HEAD;
                            end else if (n_pcount < PATH_W'(PATH_MAX_BYTES)) begin
                                n_pcount = n_pcount + 1'b1;
                                if (n_pcount >= PATH_W'(PATH_MAX_BYTES)) begin
                                    n_phase = PH_HEAD;
                                end
                                e_valid = 1'b1;
                                e_kind  = KIND_PATH;
                                e_value = b;
                            end else begin
                                n_phase = PH_HEAD;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // content-length search and number parse
                    unique case (n_nph)
                        NUM_IDLE: begin
                            if (n_name < NAME_LEN && c == name_char(n_name)) begin
                                n_name = n_name + 1'b1;
                                if (n_name == NAME_LEN) begin
                                    n_nph  = NUM_SPACE;
                                    n_name = '0;
                                end
                            end else begin
                                n_name = (c == "c") ? 4'd1 : 4'd0;
                            end
                        end
                        NUM_SPACE: begin
                            if (!space) begin
                                if (b == "+") begin
                                    n_nph = NUM_DIGITS;
                                end else if (b == "-") begin
                                    n_neg = 1'b1;
                                    n_nph = NUM_DIGITS;
                                end else if (digit) begin
                                    n_len = LEN_W'(b - "0");
                                    n_nph = NUM_DIGITS;
                                end else begin
                                    n_nph = NUM_END;
                                end
                            end
                        end
                        NUM_DIGITS: begin
                            if (digit) begin
                                v = ({4'd0, n_len} << 3) + ({4'd0, n_len} << 1)
                                    + (LEN_W+4)'(b - "0");
                                n_len = (v > (LEN_W+4)'(LEN_SAT)) ? LEN_SAT : v[LEN_W-1:0];
                            end else begin
                                n_nph = NUM_END;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // blank line detection
                    if (n_end == 2'd3 && b == CH_LF) begin
                        n_end   = '0;
                        end_hit = 1'b1;
                    end else if (b == CH_CR) begin
                        n_end = (n_end == 2'd2) ? 2'd3 : 2'd1;
                    end else if (b == CH_LF && n_end == 2'd1) begin
                        n_end = 2'd2;
                    end else begin
                        n_end = '0;
                    end

                    if (end_hit) begin
                        n_head  = n_bytes;
                        known   = (n_mm == mlen);
                        e_value = '0;
                        if (!known) begin
                            n_phase = PH_DONE;
                            e_valid = 1'b1;
                            e_kind  = KIND_BAD;
                            e_last  = 1'b1;
                        end else if (!n_post) begin
                            n_btarget = '0;
                            n_phase   = PH_DONE;
                            e_valid   = 1'b1;
                            e_kind    = KIND_DONE;
                            e_last    = 1'b1;
                        end else begin
                            tgt_raw = n_neg ? '0 : n_len;
                            if (SUM_W'(n_head) + SUM_W'(tgt_raw) >= SUM_W'(BUFFER_BYTES)) begin
                                n_btarget = CNT_W'(BUFFER_BYTES - 1) - n_head;
                            end else begin
                                n_btarget = CNT_W'(tgt_raw);
                            end
                            if (n_btarget == '0) begin
                                n_phase = PH_DONE;
                                e_valid = 1'b1;
                                e_kind  = KIND_DONE;
                                e_last  = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
            end
        end

        known    = (n_mm == (n_post ? POST_LEN : GET_LEN)) && (e_kind != KIND_BAD);
        e_method = known ? n_post : 1'b0;
        e_body   = (known && n_post) ? OUT_W'(n_btarget) : '0;
        e_head   = OUT_W'(n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_METHOD;
            r_bytes     <= '0;
            r_mm        <= '0;
            r_post      <= 1'b0;
            r_pcount    <= '0;
            r_end       <= '0;
            r_name      <= '0;
            r_nph       <= NUM_IDLE;
            r_neg       <= 1'b0;
            r_len       <= '0;
            r_head      <= '0;
            r_bcount    <= '0;
            r_btarget   <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process && e_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase   <= n_phase;
            r_bytes   <= n_bytes;
            r_mm      <= n_mm;
            r_post    <= n_post;
            r_pcount  <= n_pcount;
            r_end     <= n_end;
            r_name    <= n_name;
            r_nph     <= n_nph;
            r_neg     <= n_neg;
            r_len     <= n_len;
            r_head    <= n_head;
            r_bcount  <= n_bcount;
            r_btarget <= n_btarget;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_start <= i_req.start_req;
            r_in_byte  <= i_req.data_byte;
        end
        if (process && e_valid) begin
            r_out_kind   <= e_kind;
            r_out_value  <= e_value;
            r_out_method <= e_method;
            r_out_body   <= e_body;
            r_out_head   <= e_head;
            r_out_last   <= e_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.value       = r_out_value;
    assign o_res.method      = r_out_method;
    assign o_res.body_length = r_out_body;
    assign o_res.head_length = r_out_head;
    assign o_res.last        = r_out_last;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out_value))
        else $error("stalled result was lost or changed");

    a_body_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_BODY |-> r_out_method && r_out_body != '0)
        else $error("body byte without post method");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == KIND_BAD || r_out_kind == KIND_DONE)
        |-> r_out_last && r_out_value == '0)
        else $error("final result not marked last");

    a_path_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_PATH |-> !r_out_last && r_out_head == '0)
        else $error("path byte after header end");

    a_byte_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= CNT_W'(BUFFER_BYTES - 1))
        else $error("byte count beyond buffer");

endmodule
